// File: design/stdg_pkg.sv
`default_nettype none

package stdg_pkg;

    // calendar clock, always held normalised
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_IDENT  = 3'd0,
        CFG_LENGTH = 3'd1,
        CFG_OFFSET = 3'd2,
        CFG_SIGN   = 3'd3,
        CFG_START  = 3'd4
    } cfg_index_t;

    // zone settings seen by the clock keeper
    typedef struct packed {
        logic        sign;
        logic [4:0]  offset;
        logic [41:0] start;
    } zone_cfg_t;

    // header fields seen by the framer
    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] length;
        logic [4:0]  offset;
        logic        sign;
    } hdr_cfg_t;

    // per-tick snapshot handed to the framer
    typedef struct packed {
        logic [7:0] number;
        cal_t       utc;
        cal_t       loc;
        logic [1:0] attr;
    } frame_t;

    localparam logic [4:0] LAST_BYTE  = 5'd25;
    localparam logic [4:0] MAX_OFFSET = 5'd23;

    localparam logic [15:0] IDENT_RESET  = 16'd255;
    localparam logic [15:0] LENGTH_RESET = 16'd26;
    localparam logic [4:0]  OFFSET_RESET = 5'd1;
    localparam logic        SIGN_RESET   = 1'b1;
    localparam logic [41:0] START_RESET  = 42'd135698452190;

    // 2022-01-01 00:59:30 and the local time one hour behind it
    localparam cal_t UTC_RESET = '{year: 16'd2022, month: 4'd1, day: 5'd1,
                                   hour: 5'd0, minute: 6'd59, second: 6'd30};
    localparam cal_t LOCAL_RESET = '{year: 16'd2021, month: 4'd12, day: 5'd31,
                                     hour: 5'd23, minute: 6'd59, second: 6'd30};

endpackage

`default_nettype wire

// File: design/stdg_clocks.sv
`default_nettype none

module stdg_clocks (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic                efficiency,
    input  logic                validity,
    input  stdg_pkg::zone_cfg_t zone,
    output logic                frame_valid,
    input  logic                frame_ready,
    output stdg_pkg::frame_t    frame
);
    import stdg_pkg::*;

    // y mod 25 == 0 by folding: 256 = 6 and 128 = 3 (mod 25)
    function automatic logic mult25(logic [15:0] y);
        logic [10:0] r1;
        logic [7:0]  r2;
        r1 = ({3'b000, y[15:8]} << 2) + ({3'b000, y[15:8]} << 1) + {3'b000, y[7:0]};
        r2 = {3'b000, r1[10:7], 1'b0} + {4'b0000, r1[10:7]} + {1'b0, r1[6:0]};
        return (r2 == 8'd0) || (r2 == 8'd25) || (r2 == 8'd50) || (r2 == 8'd75) ||
               (r2 == 8'd100) || (r2 == 8'd125) || (r2 == 8'd150);
    endfunction

    // multiple of 25 and of 4 is a century year: leap only if also a multiple of 16
    function automatic logic is_leap(logic [15:0] y);
        return (y[1:0] == 2'b00) && (!mult25(y) || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] days_of(logic [3:0] m, logic leap);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic cal_t next_day(cal_t c, logic leap);
        cal_t r;
        r = c;
        if (c.day >= days_of(c.month, leap))
        begin
            r.day = 5'd1;
            if (c.month >= 4'd12)
            begin
                r.month = 4'd1;
                r.year  = c.year + 16'd1;
            end
            else
            begin
                r.month = c.month + 4'd1;
            end
        end
        else
        begin
            r.day = c.day + 5'd1;
        end
        return r;
    endfunction

    function automatic cal_t prev_day(cal_t c, logic leap);
        cal_t r;
        r = c;
        if (c.day > 5'd1)
        begin
            r.day = c.day - 5'd1;
        end
        else if (c.month > 4'd1)
        begin
            r.month = c.month - 4'd1;
            r.day   = days_of(c.month - 4'd1, leap);
        end
        else
        begin
            r.month = 4'd12;
            r.year  = c.year - 16'd1;
            r.day   = 5'd31;
        end
        return r;
    endfunction

    function automatic cal_t tick(cal_t c);
        cal_t r;
        r = c;
        if (c.second < 6'd59)
        begin
            r.second = c.second + 6'd1;
        end
        else
        begin
            r.second = 6'd0;
            if (c.minute < 6'd59)
            begin
                r.minute = c.minute + 6'd1;
            end
            else
            begin
                r.minute = 6'd0;
                if (c.hour < 5'd23)
                begin
                    r.hour = c.hour + 5'd1;
                end
                else
                begin
                    r.hour = 5'd0;
                    r = next_day(r, is_leap(c.year));
                end
            end
        end
        return r;
    endfunction

    // unpack and clamp the start word
    function automatic cal_t load_utc(logic [41:0] st);
        cal_t       r;
        logic [4:0] dmax;
        r.second = (st[5:0] > 6'd59) ? 6'd59 : st[5:0];
        r.minute = (st[11:6] > 6'd59) ? 6'd59 : st[11:6];
        r.hour   = (st[16:12] > 5'd23) ? 5'd23 : st[16:12];
        r.year   = st[41:26];
        if (st[25:22] == 4'd0)
            r.month = 4'd1;
        else if (st[25:22] > 4'd12)
            r.month = 4'd12;
        else
            r.month = st[25:22];
        dmax = days_of(r.month, is_leap(r.year));
        if (st[21:17] == 5'd0)
            r.day = 5'd1;
        else if (st[21:17] > dmax)
            r.day = dmax;
        else
            r.day = st[21:17];
        return r;
    endfunction

    function automatic cal_t derive_local(cal_t u, logic sign, logic [4:0] off);
        cal_t       r;
        logic       leap;
        logic [5:0] h6;
        r    = u;
        leap = is_leap(u.year);
        if (sign)
        begin
            h6 = {1'b0, u.hour} + 6'd24 - {1'b0, off};
            if (u.hour < off)
            begin
                r.hour = h6[4:0];
                r = prev_day(r, leap);
            end
            else
            begin
                r.hour = u.hour - off;
            end
        end
        else
        begin
            h6 = {1'b0, u.hour} + {1'b0, off};
            if (h6 >= 6'd24)
            begin
                h6 = h6 - 6'd24;
                r.hour = h6[4:0];
                r = next_day(r, leap);
            end
            else
            begin
                r.hour = h6[4:0];
            end
        end
        return r;
    endfunction

    logic       stage_valid_reg, stage_valid_next;
    opcode_t    stage_op_reg;
    logic [1:0] stage_attr_reg;
    logic [7:0] number_reg, number_next;
    cal_t       utc_reg, utc_next;
    cal_t       loc_reg, loc_next;

    logic stage_move;
    logic in_fire;
    cal_t utc_load;
    cal_t utc_tick;
    cal_t loc_tick;

    assign stage_move  = stage_valid_reg && ((stage_op_reg == OP_RESTART) || frame_ready);
    assign frame_valid = stage_valid_reg && (stage_op_reg == OP_TICK);
    assign in_ready    = !stage_valid_reg || stage_move;
    assign in_fire     = in_valid && in_ready;

    assign utc_load = load_utc(zone.start);
    assign utc_tick = tick(utc_reg);
    assign loc_tick = tick(loc_reg);

    assign frame.number = number_reg + 8'd1;
    assign frame.utc    = utc_tick;
    assign frame.loc    = loc_tick;
    assign frame.attr   = stage_attr_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        number_next      = number_reg;
        utc_next         = utc_reg;
        loc_next         = loc_reg;
        if (stage_move)
        begin
            stage_valid_next = 1'b0;
            if (stage_op_reg == OP_RESTART)
            begin
                utc_next = utc_load;
                loc_next = derive_local(utc_load, zone.sign, zone.offset);
            end
            else
            begin
                number_next = number_reg + 8'd1;
                utc_next    = utc_tick;
                loc_next    = loc_tick;
            end
        end
        if (in_fire)
            stage_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            number_reg      <= 8'd0;
            utc_reg         <= UTC_RESET;
            loc_reg         <= LOCAL_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            number_reg      <= number_next;
            utc_reg         <= utc_next;
            loc_reg         <= loc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_op_reg   <= opcode_t'(opcode);
            stage_attr_reg <= {validity, efficiency};
        end
    end

    // frame counter steps once per tick, never on a restart
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_move && (stage_op_reg == OP_TICK) |=> number_reg == $past(number_reg) + 8'd1)
        else $error("frame counter did not step on tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        stage_move && (stage_op_reg == OP_RESTART) |=> number_reg == $past(number_reg))
        else $error("frame counter moved on restart");

    // a held request keeps its opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_move |=> stage_valid_reg && $stable(stage_op_reg))
        else $error("stalled request lost");

    // both clocks stay normalised
    assert property (@(posedge clk) disable iff (!rst_n)
        (utc_reg.second < 6'd60) && (utc_reg.minute < 6'd60) && (utc_reg.hour < 5'd24) &&
        (utc_reg.month >= 4'd1) && (utc_reg.month <= 4'd12) && (utc_reg.day >= 5'd1) &&
        (loc_reg.second < 6'd60) && (loc_reg.minute < 6'd60) && (loc_reg.hour < 5'd24) &&
        (loc_reg.month >= 4'd1) && (loc_reg.month <= 4'd12) && (loc_reg.day >= 5'd1))
        else $error("clock out of range");

endmodule

`default_nettype wire

// File: design/stdg_framer.sv
`default_nettype none

module stdg_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_ready,
    input  stdg_pkg::frame_t   frame,
    input  stdg_pkg::hdr_cfg_t hdr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_byte,
    output logic               frame_last
);
    import stdg_pkg::*;

    frame_t     snap_reg;
    logic [4:0] index_reg, index_next;
    logic       busy_reg, busy_next;
    logic [7:0] acc_reg, acc_next;

    logic is_last;
    logic out_fire;
    logic load;

    assign is_last     = (index_reg == LAST_BYTE);
    assign out_fire    = busy_reg && out_ready;
    assign frame_ready = !busy_reg || (out_ready && is_last);
    assign load        = frame_valid && frame_ready;
    assign out_valid   = busy_reg;
    assign frame_last  = is_last;

    // byte select; spare bytes read as zero, the final byte is the running XOR
    always_comb
    begin
        unique case (index_reg)
            5'd0:    frame_byte = snap_reg.number;
            5'd1:    frame_byte = hdr.ident[7:0];
            5'd2:    frame_byte = hdr.ident[15:8];
            5'd3:    frame_byte = hdr.length[7:0];
            5'd4:    frame_byte = hdr.length[15:8];
            5'd5:    frame_byte = {3'b000, hdr.offset};
            5'd6:    frame_byte = {7'b0000000, hdr.sign};
            5'd8:    frame_byte = {2'b00, snap_reg.utc.second};
            5'd9:    frame_byte = {2'b00, snap_reg.utc.minute};
            5'd10:   frame_byte = {3'b000, snap_reg.utc.hour};
            5'd11:   frame_byte = {3'b000, snap_reg.utc.day};
            5'd12:   frame_byte = {4'b0000, snap_reg.utc.month};
            5'd13:   frame_byte = snap_reg.utc.year[7:0];
            5'd14:   frame_byte = snap_reg.utc.year[15:8];
            5'd16:   frame_byte = {2'b00, snap_reg.loc.second};
            5'd17:   frame_byte = {2'b00, snap_reg.loc.minute};
            5'd18:   frame_byte = {3'b000, snap_reg.loc.hour};
            5'd19:   frame_byte = {3'b000, snap_reg.loc.day};
            5'd20:   frame_byte = {4'b0000, snap_reg.loc.month};
            5'd21:   frame_byte = snap_reg.loc.year[7:0];
            5'd22:   frame_byte = snap_reg.loc.year[15:8];
            5'd24:   frame_byte = {6'b000000, snap_reg.attr};
            5'd25:   frame_byte = acc_reg;
            default: frame_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        index_next = index_reg;
        busy_next  = busy_reg;
        acc_next   = acc_reg;
        if (load)
        begin
            index_next = 5'd0;
            busy_next  = 1'b1;
            acc_next   = 8'h00;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                index_next = index_reg + 5'd1;
                acc_next   = acc_reg ^ frame_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            index_reg <= 5'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load)
            snap_reg <= frame;
    end

endmodule

`default_nettype wire

// File: design/second_tick_time_datagram.sv
`default_nettype none

// Second-tick time frame generator. Keeps a UTC calendar clock and a local
// clock (Gregorian leap years) plus an 8-bit wrapping frame counter. A restart
// request reloads UTC from start_time, clamping out-of-range fields, and sets
// local time to UTC minus (zone_sign 1) or plus (zone_sign 0) the hour offset,
// which saturates at 23. A tick request advances both clocks by one second and
// sends a 26-byte frame, one byte per out handshake, frame_last marking the
// XOR checksum in byte 25. Flow: a request waits in the input stage; a
// restart is then done, a tick hands its snapshot to the byte serialiser
// once that is idle or sending its last byte, and stalls in the stage
// until then. The next request is accepted while a frame is
// still going out. Configuration writes are taken every cycle (cfg_ready is
// always high); clock-related registers act at the next restart, header
// fields show in every frame as currently written.

module second_tick_time_datagram (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [41:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        efficiency,
    input  logic        validity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        frame_last
);
    import stdg_pkg::*;

    logic [15:0] ident_reg;
    logic [15:0] length_reg;
    logic [4:0]  offset_reg;
    logic        sign_reg;
    logic [41:0] start_reg;

    logic [4:0]  eff_offset;
    zone_cfg_t   zone;
    hdr_cfg_t    hdr;
    logic        frame_valid;
    logic        frame_ready;
    frame_t      frame;

    assign cfg_ready = 1'b1;

    // register file; unknown indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg  <= IDENT_RESET;
            length_reg <= LENGTH_RESET;
            offset_reg <= OFFSET_RESET;
            sign_reg   <= SIGN_RESET;
            start_reg  <= START_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDENT:  ident_reg  <= cfg_data[15:0];
                CFG_LENGTH: length_reg <= cfg_data[15:0];
                CFG_OFFSET: offset_reg <= cfg_data[4:0];
                CFG_SIGN:   sign_reg   <= cfg_data[0];
                CFG_START:  start_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // offset saturates; the saturated value is also what byte 5 reports
    assign eff_offset = (offset_reg > MAX_OFFSET) ? MAX_OFFSET : offset_reg;

    assign zone.sign   = sign_reg;
    assign zone.offset = eff_offset;
    assign zone.start  = start_reg;

    assign hdr.ident  = ident_reg;
    assign hdr.length = length_reg;
    assign hdr.offset = eff_offset;
    assign hdr.sign   = sign_reg;

    // input stage and both calendar clocks
    stdg_clocks u_clocks (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .efficiency  (efficiency),
        .validity    (validity),
        .zone        (zone),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // snapshot register and byte serialiser with running checksum
    stdg_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .hdr         (hdr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last)
    );

endmodule

`default_nettype wire

// File: dv/second_tick_time_datagram_test.sv
`default_nettype none

module second_tick_time_datagram_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stdg_pkg::*;

    localparam int N_RANDOM      = 250;   // random requests after the directed table
    localparam int SETTLE_CYCLES = 8;     // input stage plus margin, covers a trailing restart
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off in the pressure phase
    localparam int MAX_GAP       = 12;
    localparam int LIMIT_CYCLES  = 800000;
    localparam int PRINT_CAP     = 40;

    // register indexes the block does not decode
    localparam logic [2:0] UNMAPPED_LO  = 3'd5;
    localparam logic [2:0] UNMAPPED_MID = 3'd6;
    localparam logic [2:0] UNMAPPED_HI  = 3'd7;

    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int YEAR_SEEDS [7] = '{0, 1900, 2000, 2022, 2024, 2100, 65535};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [41:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic        efficiency;
    logic        validity;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_byte;
    logic        frame_last;

    second_tick_time_datagram u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .efficiency (efficiency),
        .validity   (validity),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

    // one byte of a frame still owed by the block
    typedef struct packed {
        logic [4:0] pos;
        logic       last;
        logic [7:0] data;
    } due_byte_t;

    // directed table: either a register write or a request, with the clocks
    // typed in where they are obvious
    typedef enum logic {
        ROW_REG,
        ROW_REQ
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        opcode_t     op;
        logic        eff;
        logic        val;
        logic        typed;
        logic [2:0]  idx;
        logic [41:0] data;
        cal_t        utc;
        cal_t        loc;
    } plan_row_t;

    due_byte_t frame_bytes_due [$];
    plan_row_t plan [$];

    // predictor copy of registers and clocks
    logic [15:0] ident_reg;
    logic [15:0] length_reg;
    logic [4:0]  offset_reg;
    logic        sign_reg;
    logic [41:0] start_reg;
    logic [7:0]  frame_count;
    cal_t        utc_now;
    cal_t        local_now;

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold = 0;

    // ------------------------------------------------------------------
    // calendar arithmetic
    // ------------------------------------------------------------------

    function automatic bit is_leap(logic [15:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(logic [3:0] m, logic [15:0] y);
        if (m < 1 || m > 12)
            return 31;
        if (m == 2 && is_leap(y))
            return 29;
        return MONTH_LEN[m - 4'd1];
    endfunction

    function automatic cal_t day_forward(cal_t c);
        int d;
        int m;
        d = c.day + 1;
        m = c.month;
        if (d > month_days(c.month, c.year))
        begin
            d = 1;
            m = m + 1;
            if (m > 12)
            begin
                m = 1;
                c.year = c.year + 16'd1;
            end
        end
        c.day = d[4:0];
        c.month = m[3:0];
        return c;
    endfunction

    function automatic cal_t day_back(cal_t c);
        if (c.day > 1)
        begin
            c.day = c.day - 5'd1;
        end
        else
        begin
            if (c.month > 1)
            begin
                c.month = c.month - 4'd1;
            end
            else
            begin
                c.month = 4'd12;
                c.year = c.year - 16'd1;
            end
            c.day = 5'(month_days(c.month, c.year));
        end
        return c;
    endfunction

    // clocks are always normalised, so no field overflows its width here
    function automatic cal_t second_forward(cal_t c);
        c.second = c.second + 6'd1;
        if (c.second < 60)
            return c;
        c.second = 6'd0;
        c.minute = c.minute + 6'd1;
        if (c.minute < 60)
            return c;
        c.minute = 6'd0;
        c.hour = c.hour + 5'd1;
        if (c.hour < 24)
            return c;
        c.hour = 5'd0;
        return day_forward(c);
    endfunction

    function automatic cal_t clamp_start(logic [41:0] st);
        cal_t c;
        c = cal_t'(st);
        if (c.second > 59)
            c.second = 6'd59;
        if (c.minute > 59)
            c.minute = 6'd59;
        if (c.hour > 23)
            c.hour = 5'd23;
        if (c.month < 1)
            c.month = 4'd1;
        if (c.month > 12)
            c.month = 4'd12;
        if (c.day < 1)
            c.day = 5'd1;
        if (c.day > month_days(c.month, c.year))
            c.day = 5'(month_days(c.month, c.year));
        return c;
    endfunction

    function automatic logic [4:0] capped_offset();
        return (offset_reg > MAX_OFFSET) ? MAX_OFFSET : offset_reg;
    endfunction

    // sign 1 moves local time back by the offset, sign 0 forward
    function automatic cal_t zone_shift(cal_t u, logic [4:0] off, logic sgn);
        cal_t c;
        int   h;
        c = u;
        if (sgn)
        begin
            if (c.hour < off)
            begin
                c.hour = 5'(c.hour + 24 - off);
                c = day_back(c);
            end
            else
            begin
                c.hour = c.hour - off;
            end
        end
        else
        begin
            h = c.hour + off;
            if (h >= 24)
            begin
                c.hour = 5'(h - 24);
                c = day_forward(c);
            end
            else
            begin
                c.hour = 5'(h);
            end
        end
        return c;
    endfunction

    function automatic cal_t cal(int y, int mo, int d, int h, int mi, int s);
        cal_t c;
        c.year = 16'(y);
        c.month = 4'(mo);
        c.day = 5'(d);
        c.hour = 5'(h);
        c.minute = 6'(mi);
        c.second = 6'(s);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // predictor: updates the clocks and queues the frame a tick produces
    // ------------------------------------------------------------------

    task automatic predict_datagram(opcode_t op, logic eff, logic val,
                                    logic typed, cal_t t_utc, cal_t t_loc);
        logic [7:0] fb [26];
        logic [7:0] sum;
        cal_t       u;
        cal_t       l;
        due_byte_t  d;
        if (op == OP_RESTART)
        begin
            // frame counter is kept, nothing is sent
            utc_now = clamp_start(start_reg);
            local_now = zone_shift(utc_now, capped_offset(), sign_reg);
        end
        else
        begin
            frame_count = frame_count + 8'd1;
            utc_now = second_forward(utc_now);
            local_now = second_forward(local_now);
            u = typed ? t_utc : utc_now;
            l = typed ? t_loc : local_now;
            fb[0]  = frame_count;
            fb[1]  = ident_reg[7:0];
            fb[2]  = ident_reg[15:8];
            fb[3]  = length_reg[7:0];
            fb[4]  = length_reg[15:8];
            fb[5]  = {3'b000, capped_offset()};
            fb[6]  = {7'b0000000, sign_reg};
            fb[7]  = 8'd0;
            fb[8]  = {2'b00, u.second};
            fb[9]  = {2'b00, u.minute};
            fb[10] = {3'b000, u.hour};
            fb[11] = {3'b000, u.day};
            fb[12] = {4'b0000, u.month};
            fb[13] = u.year[7:0];
            fb[14] = u.year[15:8];
            fb[15] = 8'd0;
            fb[16] = {2'b00, l.second};
            fb[17] = {2'b00, l.minute};
            fb[18] = {3'b000, l.hour};
            fb[19] = {3'b000, l.day};
            fb[20] = {4'b0000, l.month};
            fb[21] = l.year[7:0];
            fb[22] = l.year[15:8];
            fb[23] = 8'd0;
            fb[24] = {6'd0, val, eff};
            sum = 8'd0;
            for (int i = 0; i < 25; i++)
                sum = sum ^ fb[i];
            fb[25] = sum;
            for (int i = 0; i < 26; i++)
            begin
                d.pos = 5'(i);
                d.last = (i == LAST_BYTE);
                d.data = fb[i];
                frame_bytes_due.push_back(d);
            end
        end
    endtask

    task automatic apply_reg(logic [2:0] idx, logic [41:0] data);
        unique case (idx)
            CFG_IDENT:  ident_reg = data[15:0];
            CFG_LENGTH: length_reg = data[15:0];
            CFG_OFFSET: offset_reg = data[4:0];
            CFG_SIGN:   sign_reg = data[0];
            CFG_START:  start_reg = data;
            default:    ; // unmapped index, dropped
        endcase
    endtask

    task automatic report(string what, int pos, logic [7:0] want, logic [7:0] got);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("mismatch: %s at byte %0d, want %h got %h", what, pos, want, got);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // wait for every owed byte, then let a trailing restart clear the input stage
    task automatic settle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [41:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    // valid stays up across back-to-back requests, lowered only for a gap
    task automatic offer_request(opcode_t op, logic eff, logic val);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        efficiency <= eff;
        validity <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [41:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return r[41:0];
        endcase
    endfunction

    // start times mostly sit just before a rollover so that a few ticks cross it
    function automatic logic [41:0] pick_start();
        cal_t c;
        int   y;
        if ($urandom_range(0, 3) == 0)
            return pick_value();
        y = YEAR_SEEDS[$urandom_range(0, 6)] + $urandom_range(0, 2) - 1;
        c.year = 16'(y);
        c.month = 4'($urandom_range(0, 15));
        c.day = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(27, 31));
        case ($urandom_range(0, 2))
            0:       c.hour = 5'($urandom_range(0, 31));
            1:       c.hour = 5'($urandom_range(0, 3));
            default: c.hour = 5'($urandom_range(20, 23));
        endcase
        c.minute = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(58, 59));
        c.second = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(55, 59));
        return c;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [41:0] data);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t req_row(opcode_t op, logic eff, logic val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.op = op;
        r.eff = eff;
        r.val = val;
        return r;
    endfunction

    function automatic plan_row_t timed_row(logic eff, logic val, cal_t u, cal_t l);
        plan_row_t r;
        r = req_row(OP_TICK, eff, val);
        r.typed = 1'b1;
        r.utc = u;
        r.loc = l;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, watchdog, receiver
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: checks each accepted byte against the oldest owed one, then
    // draws its stall; a pending hold-off from the stimulus overrides it
    initial
    begin
        due_byte_t due;
        int        rx_gap;
        rx_gap = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    report("byte with no frame owed", 0, 8'd0, frame_byte);
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame_byte !== due.data)
                        report("frame_byte", int'(due.pos), due.data, frame_byte);
                    if (frame_last !== due.last)
                        report("frame_last", int'(due.pos), {7'd0, due.last},
                               {7'd0, frame_last});
                end
                rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int        phase;
        int        sent;
        int        batch;
        bit        busy;
        opcode_t   op;
        plan_row_t row;

        in_valid = 1'b0;
        opcode = OP_TICK;
        efficiency = 1'b0;
        validity = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDENT;
        cfg_data = '0;
        rst_n = 1'b0;

        // predictor at reset
        ident_reg = IDENT_RESET;
        length_reg = LENGTH_RESET;
        offset_reg = OFFSET_RESET;
        sign_reg = SIGN_RESET;
        start_reg = START_RESET;
        frame_count = 8'd0;
        utc_now = clamp_start(start_reg);
        local_now = zone_shift(utc_now, capped_offset(), sign_reg);

        // reset state: UTC just before 01:00, local an hour behind in the old year
        plan.push_back(timed_row(1'b0, 1'b0, cal(2022, 1, 1, 0, 59, 31),
                                 cal(2021, 12, 31, 23, 59, 31)));
        plan.push_back(timed_row(1'b1, 1'b1, cal(2022, 1, 1, 0, 59, 32),
                                 cal(2021, 12, 31, 23, 59, 32)));
        // restart keeps the frame counter and reloads the clocks
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(timed_row(1'b1, 1'b0, cal(2022, 1, 1, 0, 59, 31),
                                 cal(2021, 12, 31, 23, 59, 31)));
        // header extremes; clock registers wait for the next restart
        plan.push_back(reg_row(CFG_IDENT, 42'd0));
        plan.push_back(reg_row(CFG_LENGTH, 42'd0));
        plan.push_back(reg_row(CFG_OFFSET, 42'd0));
        plan.push_back(reg_row(CFG_SIGN, 42'd0));
        plan.push_back(reg_row(CFG_START, cal(2023, 12, 31, 23, 59, 59)));
        plan.push_back(timed_row(1'b0, 1'b1, cal(2022, 1, 1, 0, 59, 32),
                                 cal(2021, 12, 31, 23, 59, 32)));
        plan.push_back(req_row(OP_RESTART, 1'b1, 1'b1));
        plan.push_back(timed_row(1'b1, 1'b1, cal(2024, 1, 1, 0, 0, 0),
                                 cal(2024, 1, 1, 0, 0, 0)));
        // offset above 23 saturates; zero month and day clamp; year borrows to 65535
        plan.push_back(reg_row(CFG_IDENT, 42'hFFFF));
        plan.push_back(reg_row(CFG_LENGTH, 42'hFFFF));
        plan.push_back(reg_row(CFG_OFFSET, 42'd31));
        plan.push_back(reg_row(CFG_SIGN, 42'd1));
        plan.push_back(reg_row(CFG_START, 42'd0));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(timed_row(1'b0, 1'b0, cal(0, 1, 1, 0, 0, 1),
                                 cal(65535, 12, 31, 1, 0, 1)));
        // all fields out of range saturate; year 65535 wraps to 0 on the tick
        plan.push_back(reg_row(CFG_OFFSET, 42'd0));
        plan.push_back(reg_row(CFG_SIGN, 42'd0));
        plan.push_back(reg_row(CFG_START, '1));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(timed_row(1'b0, 1'b0, cal(0, 1, 1, 0, 0, 0),
                                 cal(0, 1, 1, 0, 0, 0)));
        // leap years: day 30 in a leap February, forward carry into March
        plan.push_back(reg_row(CFG_OFFSET, 42'd23));
        plan.push_back(reg_row(CFG_START, cal(2024, 2, 30, 0, 59, 59)));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(req_row(OP_TICK, 1'b1, 1'b0));
        // century not a leap year
        plan.push_back(reg_row(CFG_OFFSET, 42'd1));
        plan.push_back(reg_row(CFG_START, cal(1900, 2, 29, 23, 59, 59)));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(req_row(OP_TICK, 1'b0, 1'b1));
        // 400-year rule: 2000 is leap
        plan.push_back(reg_row(CFG_OFFSET, 42'd0));
        plan.push_back(reg_row(CFG_SIGN, 42'd1));
        plan.push_back(reg_row(CFG_START, cal(2000, 2, 28, 23, 59, 59)));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(req_row(OP_TICK, 1'b1, 1'b1));
        // borrow back across a non-leap February end
        plan.push_back(reg_row(CFG_OFFSET, 42'd5));
        plan.push_back(reg_row(CFG_START, cal(2100, 3, 1, 0, 0, 0)));
        plan.push_back(req_row(OP_RESTART, 1'b0, 1'b0));
        plan.push_back(req_row(OP_TICK, 1'b0, 1'b0));
        // writes to unmapped indexes must change nothing
        plan.push_back(reg_row(UNMAPPED_LO, '1));
        plan.push_back(reg_row(UNMAPPED_MID, 42'h2AAAAAAAAAA));
        plan.push_back(reg_row(UNMAPPED_HI, 42'd0));
        plan.push_back(req_row(OP_TICK, 1'b1, 1'b0));
        plan.push_back(req_row(OP_TICK, 1'b0, 1'b1));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        busy = 1'b0;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_REG)
            begin
                if (busy)
                    settle();
                busy = 1'b0;
                write_reg(row.idx, row.data);
            end
            else
            begin
                offer_request(row.op, row.eff, row.val);
                predict_datagram(row.op, row.eff, row.val, row.typed, row.utc, row.loc);
                busy = 1'b1;
            end
        end

        // random phases: new settings, usually a restart, then a run of mostly ticks
        phase = 0;
        sent = 0;
        while (sent < N_RANDOM)
        begin
            settle();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (int r = CFG_IDENT; r <= CFG_START; r++)
            begin
                if (phase == 0 || $urandom_range(0, 1) == 1)
                    write_reg(3'(r), (r == CFG_START) ? pick_start() : pick_value());
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(3'($urandom_range(UNMAPPED_LO, UNMAPPED_HI)), pick_value());
            batch = $urandom_range(4, 30);
            if (phase == 2)
            begin
                // receiver stalls while requests keep coming, so the input backs up
                tx_idle = 1'b0;
                batch = 30;
                rx_hold = HOLD_CYCLES;
            end
            for (int k = 0; k < batch; k++)
            begin
                if (k == 0 && $urandom_range(0, 7) != 0)
                    op = OP_RESTART;
                else
                    op = ($urandom_range(0, 11) == 0) ? OP_RESTART : OP_TICK;
                row = req_row(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                offer_request(row.op, row.eff, row.val);
                predict_datagram(row.op, row.eff, row.val, 1'b0, '0, '0);
                sent++;
            end
            phase++;
        end

        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (frame_bytes_due.size() != 0)
            report("frame bytes never sent", frame_bytes_due.size(), 8'd0, 8'd0);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
design/stdg_pkg.sv
design/stdg_clocks.sv
design/stdg_framer.sv
design/second_tick_time_datagram.sv
dv/second_tick_time_datagram_test.sv
